/* rtl/core/rps_pkg.sv */
package rps_pkg;

    // field widths fixed by the stream format
    localparam int SCORE_W            = 10;
    localparam int RAND_W             = 31;
    localparam int PIDX_W             = 6;
    localparam int SQ_W               = 2 * SCORE_W;
    localparam int MAX_POPULATION_DEF = 64;

    // request kinds carried in s_tuser
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SELECT = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MOD_A,
        ST_PICK_A,
        ST_MOD_B,
        ST_PICK_B,
        ST_OUT_A,
        ST_OUT_B
    } rps_state_t;

    // what the output register is loaded with
    typedef enum logic [1:0] {
        OUT_PARENT_A,
        OUT_PARENT_B,
        OUT_FALLBACK
    } out_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     capture;
        logic     walk_start;
        logic     walk_pick;
        logic     walk_mask;
        logic     mod_start;
        logic     mod_second;
        logic     keep_first;
        logic     out_load;
        out_sel_t out_sel;
    } rps_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic walk_busy;
        logic found;
        logic div_busy;
    } rps_stat_t;

endpackage

/* rtl/core/rps_divider.sv */
module rps_divider
    import rps_pkg::*;
#(
    parameter int TOT_W = 26
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [RAND_W-1:0]  dividend,
    input  logic [TOT_W-1:0]   divisor,
    output logic               busy,
    output logic [TOT_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(RAND_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic [RAND_W-1:0] dvd_reg;
    logic [TOT_W-1:0]  rem_reg;
    logic [TOT_W-1:0]  div_reg;
    logic [TOT_W:0]    trial;
    logic [TOT_W-1:0]  rem_next;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {rem_reg, dvd_reg[RAND_W-1]};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = TOT_W'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[TOT_W-1:0];
        end
    end

    // iteration counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(RAND_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // dividend shifter, remainder and divisor
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (cnt_reg != '0) begin
            dvd_reg <= {dvd_reg[RAND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign busy      = (cnt_reg != '0);
    assign remainder = rem_reg;

endmodule

/* rtl/core/rps_datapath.sv */
module rps_datapath
    import rps_pkg::*;
#(
    parameter int MAX_POPULATION = MAX_POPULATION_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rps_cmd_t           cmd,
    input  logic [SCORE_W-1:0] score,
    input  logic               first_item,
    input  logic [RAND_W-1:0]  rand_one,
    input  logic [RAND_W-1:0]  rand_two,
    output rps_stat_t          stat,
    output logic [PIDX_W-1:0]  parent_index,
    output logic               fallback,
    output logic               last_result
);

    localparam int IDX_W = $clog2(MAX_POPULATION);
    localparam int CNT_W = $clog2(MAX_POPULATION + 1);
    localparam int TOT_W = SQ_W + IDX_W;

    // score store, single write and single registered read port
    logic [SCORE_W-1:0] mem [MAX_POPULATION];

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   cnt_base;
    logic               load_ok;

    logic [RAND_W-1:0]  rand_one_reg;
    logic [RAND_W-1:0]  rand_two_reg;

    logic               walk_act_reg;
    logic               pick_mode_reg;
    logic               mask_reg;
    logic [CNT_W-1:0]   issue_cnt_reg;
    logic               issue_en;

    logic               v1_reg;
    logic [IDX_W-1:0]   idx1_reg;
    logic [SCORE_W-1:0] rd_data_reg;
    logic               v2_reg;
    logic [IDX_W-1:0]   idx2_reg;
    logic [SQ_W-1:0]    sq_reg;

    logic [TOT_W-1:0]   acc_reg;
    logic [TOT_W-1:0]   acc_next;
    logic               hit;
    logic               found_reg;
    logic [IDX_W-1:0]   pick_idx_reg;
    logic [SQ_W-1:0]    pick_sq_reg;
    logic [IDX_W-1:0]   p0_reg;

    logic [TOT_W-1:0]   total_reg;
    logic [TOT_W-1:0]   total_next;
    logic [RAND_W-1:0]  dividend;
    logic               div_busy;
    logic [TOT_W-1:0]   rem;

    logic [PIDX_W-1:0]  out_idx_reg;
    logic               out_fb_reg;
    logic               out_last_reg;

    // load position: restart flag forces slot zero
    assign cnt_base = first_item ? '0 : count_reg;
    assign load_ok  = (cnt_base < CNT_W'(MAX_POPULATION));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.load && load_ok) begin
            count_reg <= cnt_base + CNT_W'(1);
        end
    end

    // store write and walk read
    always_ff @(posedge aclk) begin
        if (cmd.load && load_ok) begin
            mem[cnt_base[IDX_W-1:0]] <= score;
        end
        rd_data_reg <= mem[issue_cnt_reg[IDX_W-1:0]];
    end

    // random words of the select beat
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rand_one_reg <= rand_one;
            rand_two_reg <= rand_two;
        end
    end

    // walk address generator
    assign issue_en = walk_act_reg && (issue_cnt_reg < count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_act_reg  <= 1'b0;
            issue_cnt_reg <= '0;
        end else if (cmd.walk_start) begin
            walk_act_reg  <= 1'b1;
            issue_cnt_reg <= '0;
        end else if (cmd.out_load || !issue_en) begin
            walk_act_reg  <= 1'b0;
        end else begin
            issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            pick_mode_reg <= cmd.walk_pick;
            mask_reg      <= cmd.walk_mask;
        end
    end

    // read and square stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (cmd.walk_start) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= issue_en;
            v2_reg <= v1_reg && !(mask_reg && (idx1_reg == p0_reg));
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg <= issue_cnt_reg[IDX_W-1:0];
        idx2_reg <= idx1_reg;
        sq_reg   <= rd_data_reg * rd_data_reg;
    end

    // running sum and first-crossing detect
    assign acc_next = acc_reg + TOT_W'(sq_reg);
    assign hit      = pick_mode_reg && v2_reg && !found_reg && (acc_next > rem);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.walk_start) begin
            found_reg <= 1'b0;
        end else if (hit) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            acc_reg <= '0;
        end else if (v2_reg && !found_reg) begin
            acc_reg <= acc_next;
        end
        if (hit) begin
            pick_idx_reg <= idx2_reg;
            pick_sq_reg  <= sq_reg;
        end
        if (cmd.keep_first) begin
            p0_reg <= pick_idx_reg;
        end
    end

    // draw total: full sum plus one, then less the first pick
    assign total_next = cmd.mod_second ? (total_reg - TOT_W'(pick_sq_reg))
                                       : (acc_reg + TOT_W'(1));
    assign dividend   = cmd.mod_second ? rand_two_reg : rand_one_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mod_start) begin
            total_reg <= total_next;
        end
    end

    rps_divider #(
        .TOT_W (TOT_W)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (dividend),
        .divisor   (total_next),
        .busy      (div_busy),
        .remainder (rem)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            case (cmd.out_sel)
                OUT_PARENT_A: begin
                    out_idx_reg  <= PIDX_W'(p0_reg);
                    out_fb_reg   <= 1'b0;
                    out_last_reg <= 1'b0;
                end
                OUT_PARENT_B: begin
                    out_idx_reg  <= PIDX_W'(pick_idx_reg);
                    out_fb_reg   <= 1'b0;
                    out_last_reg <= 1'b1;
                end
                default: begin
                    out_idx_reg  <= '0;
                    out_fb_reg   <= 1'b1;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign stat.walk_busy = issue_en || v1_reg || v2_reg;
    assign stat.found     = found_reg;
    assign stat.div_busy  = div_busy;

    assign parent_index = out_idx_reg;
    assign fallback     = out_fb_reg;
    assign last_result  = out_last_reg;

endmodule

/* rtl/core/rps_ctrl.sv */
module rps_ctrl
    import rps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      req_type,
    input  logic      m_tready,
    input  rps_stat_t stat,
    output logic      s_tready,
    output logic      m_tvalid,
    output rps_cmd_t  cmd
);

    rps_state_t state_reg;
    rps_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_sel = OUT_FALLBACK;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (req_type == REQ_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.capture    = 1'b1;
                        cmd.walk_start = 1'b1;
                        state_next     = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                if (!stat.walk_busy) begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MOD_A;
                end
            end
            ST_MOD_A: begin
                if (!stat.div_busy) begin
                    cmd.walk_start = 1'b1;
                    cmd.walk_pick  = 1'b1;
                    state_next     = ST_PICK_A;
                end
            end
            ST_PICK_A: begin
                if (stat.found) begin
                    cmd.keep_first = 1'b1;
                    cmd.mod_start  = 1'b1;
                    cmd.mod_second = 1'b1;
                    state_next     = ST_MOD_B;
                end else if (!stat.walk_busy) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_FALLBACK;
                    state_next   = ST_OUT_B;
                end
            end
            ST_MOD_B: begin
                if (!stat.div_busy) begin
                    cmd.walk_start = 1'b1;
                    cmd.walk_pick  = 1'b1;
                    cmd.walk_mask  = 1'b1;
                    state_next     = ST_PICK_B;
                end
            end
            ST_PICK_B: begin
                if (stat.found) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_PARENT_A;
                    state_next   = ST_OUT_A;
                end else if (!stat.walk_busy) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_FALLBACK;
                    state_next   = ST_OUT_B;
                end
            end
            ST_OUT_A: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_PARENT_B;
                    state_next   = ST_OUT_B;
                end
            end
            ST_OUT_B: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/roulette_parent_select_top.sv */
// Roulette parent selection with squared-score weights. A load beat (s_tuser[0] = 0) writes one
// score into the next slot of the store; s_tuser[1] restarts the slot count first,
// and loads past MAX_POPULATION entries are dropped. A select beat (s_tuser[0] = 1) runs two
// draws without replacement and returns either two beats with the chosen load positions
// (m_tlast on the second) or one fallback beat (m_tuser set, index zero). A select runs
// one summing walk and up to two picking walks over the store's single read port (a pick
// walk ends early on a hit), and up to two bit-serial modulo passes of 31 steps each.
// The block takes one beat at a time and accepts no new beat until all results of a select
// have been taken.
module roulette_parent_select_top
    import rps_pkg::*;
#(
    parameter int MAX_POPULATION = MAX_POPULATION_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // score, rand_one, rand_two
    input  logic [1:0]  s_tuser,   // req_type, first_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // parent_index, zero fill
    output logic [0:0]  m_tuser,   // fallback
    output logic        m_tlast
);

    rps_cmd_t          cmd;
    rps_stat_t         stat;
    logic [PIDX_W-1:0] parent_index;
    logic              fallback;

    rps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser[0]),
        .m_tready (m_tready),
        .stat     (stat),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    rps_datapath #(
        .MAX_POPULATION (MAX_POPULATION)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .score        (s_tdata[SCORE_W-1:0]),
        .first_item   (s_tuser[1]),
        .rand_one     (s_tdata[SCORE_W+RAND_W-1:SCORE_W]),
        .rand_two     (s_tdata[SCORE_W+2*RAND_W-1:SCORE_W+RAND_W]),
        .stat         (stat),
        .parent_index (parent_index),
        .fallback     (fallback),
        .last_result  (m_tlast)
    );

    assign m_tdata    = {2'b00, parent_index};
    assign m_tuser[0] = fallback;

`ifndef NO_ASSERTIONS
    // input and output sides never open together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result channel active together");

    // a fallback beat is always the last one and carries index zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tdata[5:0] == 6'd0)))
        else $error("malformed fallback beat");

    // a load beat never causes a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == REQ_LOAD)) |=> !m_tvalid)
        else $error("result after load beat");

    // a select beat starts the summing walk, no result right away
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == REQ_SELECT)) |=> (!m_tvalid && !s_tready))
        else $error("select beat did not start a draw");
`endif

endmodule

/* tb/sv/roulette_parent_select_top_test.sv */
module roulette_parent_select_top_test;
    import rps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_POP    = MAX_POPULATION_DEF;
    localparam int ITEM_GOAL  = 750;
    localparam int TAIL_ITEMS = 40;
    localparam int DRAIN_CYC  = 400;

    // one input beat before packing
    typedef struct {
        logic              kind;
        logic [SCORE_W-1:0] score;
        logic              first;
        logic [RAND_W-1:0] rand_one;
        logic [RAND_W-1:0] rand_two;
    } req_beat_t;

    // one expected result beat
    typedef struct {
        logic [PIDX_W-1:0] pidx;
        logic              fallback;
        logic              last;
    } parent_beat_t;

    typedef logic [SCORE_W-1:0] score_arr_t [MAX_POP];

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;   // score, rand_one, rand_two
    logic [1:0]  s_tuser  = '0;   // req_type, first_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // parent_index, zero fill
    logic [0:0]  m_tuser;         // fallback
    logic        m_tlast;

    req_beat_t    pending_beats[$];
    parent_beat_t parents_due[$];

    // score store as seen by the checker and by the stimulus builder
    score_arr_t  pop_scores;
    int unsigned pop_count = 0;
    score_arr_t  gen_scores;
    int unsigned gen_count = 0;

    int   n_total     = 0;
    int   n_accepted  = 0;
    int   n_items     = 0;
    int   n_errors    = 0;
    logic tail_phase  = 1'b0;

    roulette_parent_select_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // 1 + sum of squared scores over entries not yet picked
    function automatic longint unsigned weight_total(input score_arr_t st,
                                                     input int unsigned cnt,
                                                     input logic [MAX_POP-1:0] taken);
        longint unsigned acc;
        acc = 1;
        for (int i = 0; i < cnt && i < MAX_POP; i++) begin
            if (!taken[i]) acc += 64'(st[i]) * 64'(st[i]);
        end
        return acc;
    endfunction

    // one weighted draw, -1 when the walk finds nothing
    function automatic int pick_entry(input score_arr_t st, input int unsigned cnt,
                                      input logic [MAX_POP-1:0] taken,
                                      input logic [RAND_W-1:0] rnd);
        longint unsigned r;
        longint unsigned run;
        r   = 64'(rnd) % weight_total(st, cnt, taken);
        run = 0;
        for (int i = 0; i < cnt && i < MAX_POP; i++) begin
            if (!taken[i]) begin
                run += 64'(st[i]) * 64'(st[i]);
                if (run > r) return i;
            end
        end
        return -1;
    endfunction

    // update the store and queue expected parents for an accepted beat
    task automatic apply_beat(input req_beat_t it);
        int                 p0;
        int                 p1;
        logic [MAX_POP-1:0] taken;
        parent_beat_t       pb;
        if (it.kind == REQ_LOAD) begin
            if (it.first) pop_count = 0;
            if (pop_count < MAX_POP) begin
                pop_scores[pop_count] = it.score;
                pop_count++;
            end
        end else begin
            taken = '0;
            p0 = pick_entry(pop_scores, pop_count, taken, it.rand_one);
            if (p0 >= 0) taken[p0] = 1'b1;
            p1 = pick_entry(pop_scores, pop_count, taken, it.rand_two);
            if (p0 < 0 || p1 < 0) begin
                pb = '{pidx: '0, fallback: 1'b1, last: 1'b1};
                parents_due.insert(parents_due.size(), pb);
            end else begin
                pb = '{pidx: PIDX_W'(p0), fallback: 1'b0, last: 1'b0};
                parents_due.insert(parents_due.size(), pb);
                pb = '{pidx: PIDX_W'(p1), fallback: 1'b0, last: 1'b1};
                parents_due.insert(parents_due.size(), pb);
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        n_errors++;
    endtask

    // stimulus builders, tracking the store as the block will see it
    task automatic queue_load(input logic [SCORE_W-1:0] sc, input logic first);
        req_beat_t it;
        it = '{kind: REQ_LOAD, score: sc, first: first,
               rand_one: RAND_W'($urandom), rand_two: RAND_W'($urandom)};
        pending_beats.insert(pending_beats.size(), it);
        if (first) gen_count = 0;
        if (gen_count < MAX_POP) begin
            gen_scores[gen_count] = sc;
            gen_count++;
            n_items++;
        end
    endtask

    task automatic queue_select(input logic [RAND_W-1:0] r1, input logic [RAND_W-1:0] r2);
        req_beat_t it;
        it = '{kind: REQ_SELECT, score: SCORE_W'($urandom), first: 1'($urandom),
               rand_one: r1, rand_two: r2};
        pending_beats.insert(pending_beats.size(), it);
        n_items++;
    endtask

    function automatic logic [SCORE_W-1:0] rand_score(input bit zero_heavy);
        if (zero_heavy) return ($urandom_range(0, 4) == 0) ? SCORE_W'($urandom) : '0;
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return SCORE_W'($urandom_range(0, 15));
            default: return SCORE_W'($urandom);
        endcase
    endfunction

    // random word, sometimes landing exactly on the squared sum
    function automatic logic [RAND_W-1:0] rand_word(input longint unsigned total);
        longint unsigned k_max;
        case ($urandom_range(0, 5))
            0: begin
                k_max = (64'h7FFF_FFFF - (total - 1)) / total;
                return RAND_W'(total - 1 + total * $urandom_range(0, 32'(k_max)));
            end
            1:       return RAND_W'($urandom_range(0, 32'(total - 1)));
            2:       return '1;
            3:       return '0;
            default: return RAND_W'($urandom);
        endcase
    endfunction

    task automatic queue_random_select();
        logic [MAX_POP-1:0] taken;
        logic [RAND_W-1:0]  r1;
        int                 p0;
        taken = '0;
        r1 = rand_word(weight_total(gen_scores, gen_count, taken));
        p0 = pick_entry(gen_scores, gen_count, taken, r1);
        if (p0 >= 0) taken[p0] = 1'b1;
        queue_select(r1, rand_word(weight_total(gen_scores, gen_count, taken)));
    endtask

    task automatic build_stimulus();
        int          n_loads;
        bit          zero_heavy;
        logic [MAX_POP-1:0] none;
        none = '0;
        // empty population
        queue_select('0, '0);
        // one entry: second draw has nothing left
        queue_load('1, 1'b1);
        queue_select('1, '1);
        // all scores zero
        queue_load('0, 1'b1);
        queue_load('0, 1'b0);
        queue_select(RAND_W'(12345), '1);
        // three entries, smallest and largest words
        queue_load('1, 1'b1);
        queue_load(SCORE_W'(1), 1'b0);
        queue_load(SCORE_W'(512), 1'b0);
        queue_select('0, '0);
        queue_select('1, RAND_W'(31'h5555_5555));
        // first word equal to the squared sum
        queue_select(RAND_W'(weight_total(gen_scores, gen_count, none) - 1), RAND_W'(7));
        // restart in the middle of a population
        queue_load(SCORE_W'(3), 1'b0);
        queue_load(SCORE_W'(4), 1'b1);
        queue_load(SCORE_W'(5), 1'b0);
        queue_select(RAND_W'(16), RAND_W'(31'h2AAA_AAAA));
        queue_select(RAND_W'(41), RAND_W'(15));

        // random part: mostly fresh populations of varied size followed by selects
        while (n_items < ITEM_GOAL) begin
            if ($urandom_range(0, 99) < 85) begin
                case ($urandom_range(0, 19))
                    0, 1, 2:          n_loads = $urandom_range(60, 70);
                    3, 4, 5, 6, 7:    n_loads = $urandom_range(7, 20);
                    default:          n_loads = $urandom_range(1, 6);
                endcase
                zero_heavy = ($urandom_range(0, 7) == 0);
                for (int i = 0; i < n_loads; i++) queue_load(rand_score(zero_heavy), i == 0);
                repeat ($urandom_range(1, 4)) queue_random_select();
            end else begin
                // loose items: extra loads, stray restarts, selects
                repeat ($urandom_range(1, 5)) begin
                    if ($urandom_range(0, 1))
                        queue_load(rand_score(1'b0), ($urandom_range(0, 3) == 0));
                    else queue_random_select();
                end
            end
        end
    endtask

    // source side: present queued beats, predict on acceptance
    always @(posedge aclk) begin
        req_beat_t cur;
        int        idle_left;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            idle_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_beat(cur);
                n_accepted++;
            end
            tail_phase <= (n_accepted >= n_total - TAIL_ITEMS);
            if (!s_tvalid || s_tready) begin
                if (idle_left > 0) begin
                    idle_left--;
                    s_tvalid <= 1'b0;
                end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
                    idle_left = $urandom_range(1, 17) - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    cur = pending_beats.pop_front();
                    s_tdata  <= {cur.rand_two, cur.rand_one, cur.score};
                    s_tuser  <= {cur.first, cur.kind};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side: random backpressure, compare each result beat
    always @(posedge aclk) begin
        parent_beat_t want;
        int           stall_left;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (parents_due.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing expected, tdata %0h",
                                              m_tdata));
                end else begin
                    want = parents_due.pop_front();
                    if (m_tdata[PIDX_W-1:0] !== want.pidx)
                        report_mismatch($sformatf("parent_index %0d, expected %0d",
                                                  m_tdata[PIDX_W-1:0], want.pidx));
                    if (m_tuser[0] !== want.fallback)
                        report_mismatch($sformatf("fallback %b, expected %b",
                                                  m_tuser[0], want.fallback));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // run control
    initial begin
        build_stimulus();
        n_total = pending_beats.size();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        while (n_accepted < n_total) @(posedge aclk);
        while (parents_due.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (parents_due.size() > 0) report_mismatch("results still expected at the end");
        if (n_errors == 0) begin
            $display("roulette_parent_select_top_test: done, clean");
        end else begin
            $display("roulette_parent_select_top_test: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #12_000_000;
        $display("roulette_parent_select_top_test: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/rps_pkg.sv
rtl/core/rps_divider.sv
rtl/core/rps_datapath.sv
rtl/core/rps_ctrl.sv
rtl/core/roulette_parent_select_top.sv
tb/sv/roulette_parent_select_top_test.sv
